// File: sv/integer_to_radix_ascii_macros.svh
// Assertion macros used by the radix converter RTL.
// No dependencies; included by itra_ctrl, which carries the concurrent assertions.
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// same-cycle implication, disabled during reset
`define ITRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ITRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/itra_pkg.sv
// Package for the radix converter: constants, datapath command/status types
// and the digit-to-ASCII function. No dependencies.
package itra_pkg;

    localparam int VALUE_BITS_DEF = 63;
    localparam int STORE_DEPTH    = 63;
    localparam int BITS_PER_STEP  = 8;
    localparam int RADIX_W        = 7;
    localparam int CHAR_W         = 7;
    localparam int DIGIT_W        = 6;
    localparam int CNT_W          = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 7'd64;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_PLUS    = 7'h2B;
    localparam logic [CHAR_W-1:0] ASCII_SLASH   = 7'h2F;

    typedef struct packed {
        logic load;   // take a new value, clear digit count
        logic step;   // one long-division step
        logic store;  // write remainder to the digit store
        logic rd;     // read next digit for output
    } dp_cmd_t;

    typedef struct packed {
        logic quot_zero;  // working quotient is zero
        logic cnt_last;   // digit store is on its last entry
        logic ptr_zero;   // read pointer at the least significant digit
    } dp_status_t;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d) inside
            [6'd0:6'd9]:   c = ASCII_ZERO + CHAR_W'(d);
            [6'd10:6'd35]: c = ASCII_UPPER_A + CHAR_W'(d) - 7'd10;
            [6'd36:6'd61]: c = ASCII_LOWER_A + CHAR_W'(d) - 7'd36;
            6'd62:         c = ASCII_PLUS;
            default:       c = ASCII_SLASH;
        endcase
        return c;
    endfunction

endpackage

// File: sv/itra_if.sv
// Channel interfaces of the radix converter: value input, character
// output and radix write. Depends on itra_pkg.
interface itra_num_if import itra_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface itra_char_if import itra_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;

    modport source (output valid, output digit_char, output last_digit, input ready);
    modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

interface itra_cfg_if import itra_pkg::*;;
    logic               valid;
    logic               ready;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

// File: sv/integer_to_radix_ascii.sv
// Integer to radix-N ASCII converter (bases 2..64), top level.
// Channels: number (value in), chars (one ASCII digit per item, last_digit
// on the final one), cfg (radix write, always ready, reset value 10).
// Radix 0/1 act as 2 and 65..127 as 64; input bits above VALUE_BITS are
// ignored. A zero input yields the single character '0'.
// Sequence: each digit takes STEPS = ceil(VALUE_BITS/8) division steps (8 quotient
// bits per cycle, set by the remainder compare chain), plus one store step.
// Once the digits are stored, characters leave at one per cycle while the
// receiver is ready, through the read port of the digit store.
// number.ready is high only while idle; the next value can be taken while
// the last character still waits in the output register.
// Reset clears the sequencer and output valid and sets radix to 10; the
// digit store needs no clearing. A stalled receiver holds the current
// character and pauses the digit reads.
// Depends on itra_pkg, itra_if, itra_datapath and itra_ctrl.
module integer_to_radix_ascii import itra_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    itra_num_if.sink   number,
    itra_char_if.source chars,
    itra_cfg_if.sink   cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    itra_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (number.valid),
        .in_ready  (number.ready),
        .out_valid (chars.valid),
        .out_last  (chars.last_digit),
        .out_ready (chars.ready),
        .cmd       (cmd),
        .status    (status)
    );

    itra_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .value      (number.value),
        .cfg_we     (cfg.valid),
        .cfg_radix  (cfg.radix),
        .digit_char (chars.digit_char)
    );

endmodule

// File: sv/itra_datapath.sv
// Datapath: radix register, 8-bit-per-cycle long divider, digit store
// memory and output digit register. Depends on itra_pkg.
module itra_datapath import itra_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  cfg_we,
    input  logic [RADIX_W-1:0]    cfg_radix,
    output logic [CHAR_W-1:0]     digit_char
);

    localparam int STEPS     = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int WORK_BITS = STEPS * BITS_PER_STEP;
    localparam int ADDR_W    = $clog2(STORE_DEPTH);

    logic [RADIX_W-1:0]       radix_reg;
    logic [RADIX_W-1:0]       radix_eff;
    logic [WORK_BITS-1:0]     work_reg;
    logic [WORK_BITS-1:0]     work_next;
    logic [RADIX_W-1:0]       rem_reg;
    logic [RADIX_W-1:0]       rem_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [ADDR_W-1:0]        ptr_reg;
    logic [DIGIT_W-1:0]       rd_reg;
    logic [DIGIT_W-1:0]       digit_mem [STORE_DEPTH];
    logic [BITS_PER_STEP-1:0] qbits;

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
            radix_eff = RADIX_MIN;
        else if (radix_reg > RADIX_MAX)
            radix_eff = RADIX_MAX;
        else
            radix_eff = radix_reg;
    end

    // restoring division, one quotient bit per inner step; remainder stays < radix
    always_comb
    begin
        logic [RADIX_W-1:0] r;
        r     = rem_reg;
        qbits = '0;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            r = {r[RADIX_W-2:0], work_reg[WORK_BITS-1-i]};
            if (r >= radix_eff)
            begin
                r = r - radix_eff;
                qbits[BITS_PER_STEP-1-i] = 1'b1;
            end
        end
        rem_next  = r;
        work_next = (work_reg << BITS_PER_STEP) | WORK_BITS'(qbits);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_we)
            radix_reg <= cfg_radix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            ptr_reg  <= '0;
        end
        else if (cmd.load)
        begin
            work_reg <= WORK_BITS'(value);
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.step)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
        else if (cmd.store)
        begin
            rem_reg <= '0;
            cnt_reg <= cnt_reg + 1'b1;
            ptr_reg <= cnt_reg[ADDR_W-1:0];
        end
        else if (cmd.rd)
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
            digit_mem[cnt_reg[ADDR_W-1:0]] <= rem_reg[DIGIT_W-1:0];
        if (cmd.rd)
            rd_reg <= digit_mem[ptr_reg];
    end

    assign status.quot_zero = (work_reg == '0);
    assign status.cnt_last  = (cnt_reg == CNT_W'(STORE_DEPTH - 1));
    assign status.ptr_zero  = (ptr_reg == '0);
    assign digit_char       = digit_ascii(rd_reg);

endmodule

// File: sv/itra_ctrl.sv
// Controller: sequences load, division steps, digit stores and output
// reads; owns the output valid/last flags. Depends on itra_pkg and macros.
`include "integer_to_radix_ascii_macros.svh"

module itra_ctrl import itra_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    output logic       out_last,
    input  logic       out_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    localparam int STEPS  = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    typedef enum logic [1:0] {
        IDLE,
        DIVIDE,
        STORE,
        EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              valid_reg, valid_next;
    logic              last_reg, last_next;
    logic              out_free;

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign out_free  = !valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        valid_next = valid_reg && !out_ready;
        last_next  = last_reg;
        cmd        = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = DIVIDE;
                end
            end
            DIVIDE:
            begin
                cmd.step = 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                    state_next = STORE;
                else
                    step_next = step_reg + 1'b1;
            end
            STORE:
            begin
                cmd.store = 1'b1;
                step_next = '0;
                if (status.quot_zero || status.cnt_last)
                    state_next = EMIT;
                else
                    state_next = DIVIDE;
            end
            EMIT:
            begin
                // digit read lands in the output register next cycle
                if (out_free)
                begin
                    cmd.rd     = 1'b1;
                    valid_next = 1'b1;
                    last_next  = status.ptr_zero;
                    if (status.ptr_zero)
                        state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            step_reg  <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    `ITRA_ASSERT_NEXT(a_load_starts_divide, clk, rst_n, in_valid && in_ready, state_reg == DIVIDE && step_reg == '0, "accepted item did not start division")
    `ITRA_ASSERT_NEXT(a_final_read_marks_last, clk, rst_n, cmd.rd && status.ptr_zero, state_reg == IDLE && valid_reg && last_reg, "final digit not flagged last")
    `ITRA_ASSERT_NEXT(a_store_continues, clk, rst_n, cmd.store && !status.quot_zero && !status.cnt_last, state_reg == DIVIDE && step_reg == '0, "nonzero quotient did not start next division")
    `ITRA_ASSERT_NOW(a_rd_only_when_free, clk, rst_n, cmd.rd, state_reg == EMIT && out_free, "digit read would overwrite a pending item")

endmodule

// File: bench/integer_to_radix_ascii_tb.sv
// Self-checking bench for integer_to_radix_ascii: converts values in its own
// digit predictor and compares every output character with the expected one.
// Depends on itra_pkg, the itra_if channel interfaces and the converter RTL.
`timescale 1ns / 1ps

module integer_to_radix_ascii_tb;
    import itra_pkg::*;

    localparam int VW         = VALUE_BITS_DEF;
    localparam int DRAIN_GAP  = 8;
    localparam int LONG_HOLD  = 300;
    localparam int TAIL_WAIT  = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_item_t;

    logic clk;
    logic rst_n;

    itra_num_if #(.VALUE_BITS(VW)) number_if ();
    itra_char_if                   chars_if ();
    itra_cfg_if                    cfg_if ();

    integer_to_radix_ascii #(.VALUE_BITS(VW)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_if),
        .chars  (chars_if),
        .cfg    (cfg_if)
    );

    string digit_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+/";

    digit_item_t        pending_digits[$];
    logic [RADIX_W-1:0] radix_setting;
    int                 error_count;
    int                 values_sent;
    int                 chars_seen;
    int                 radix_writes;
    int                 burst_left;
    bit                 hold_request;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // expected characters for one value at the current radix, MSD first
    function automatic void convert_to_digits(input logic [VW-1:0] v,
                                              input logic [RADIX_W-1:0] r);
        logic [63:0]        q;
        logic [63:0]        b;
        logic [DIGIT_W-1:0] rems[$];
        digit_item_t        item;
        b = (r < RADIX_MIN) ? 64'(RADIX_MIN) : (r > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(r);
        q = 64'(v);
        if (q == 0)
            rems.push_front('0);
        while (q != 0)
        begin
            rems.push_front(DIGIT_W'(q % b));
            q = q / b;
        end
        for (int k = 0; k < rems.size(); k++)
        begin
            item.ch        = CHAR_W'(digit_set[rems[k]]);
            item.last      = (k == rems.size() - 1);
            pending_digits = {pending_digits, item};
        end
    endfunction

    // offer one value; bursts of back-to-back items with random gaps between
    task automatic send_value(input logic [VW-1:0] v);
        number_if.valid <= 1'b1;
        number_if.value <= v;
        @(posedge clk);
        while (!number_if.ready)
            @(posedge clk);
        convert_to_digits(v, radix_setting);
        values_sent++;
        if (burst_left == 0)
        begin
            number_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
        else
            burst_left--;
    endtask

    task automatic wait_for_drain();
        number_if.valid <= 1'b0;
        while (pending_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        wait_for_drain();
        cfg_if.valid <= 1'b1;
        cfg_if.radix <= r;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        radix_setting = r;
        radix_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [VW-1:0] random_value();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        if ($urandom_range(0, 11) == 0)
            return '0;
        return VW'(raw >> $urandom_range(1, 63));
    endfunction

    // radix left at its reset value of 10
    task automatic test_reset_radix();
        send_value('0);
        send_value(VW'(1));
        send_value(VW'(9));
        send_value(VW'(10));
        send_value({VW{1'b1}});
    endtask

    task automatic test_radix_extremes();
        logic [RADIX_W-1:0] radixes[6];
        radixes = '{7'd2, 7'd64, 7'd0, 7'd1, 7'd65, 7'd127};
        foreach (radixes[i])
        begin
            write_radix(radixes[i]);
            send_value({VW{1'b1}});
            send_value(VW'(1));
        end
        write_radix(7'd36);
        send_value(VW'(35));
        write_radix(RADIX_MAX);
        send_value(VW'(62));
        send_value(VW'(63));
    endtask

    task automatic test_random_values();
        logic [RADIX_W-1:0] r;
        for (int round = 0; round < 5; round++)
        begin
            // mostly legal radixes, now and then any 7-bit code
            if ($urandom_range(0, 3) == 0)
                r = RADIX_W'($urandom_range(0, 127));
            else
                r = RADIX_W'($urandom_range(2, 64));
            write_radix(r);
            repeat (16) send_value(random_value());
        end
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_output_backpressure();
        write_radix(RADIX_RESET);
        hold_request = 1'b1;
        burst_left   = 10;
        repeat (8) send_value(VW'($urandom_range(0, 1_000_000)));
    endtask

    initial
    begin : char_sink
        int hold_left;
        int phase_left;
        int mode;
        hold_left  = 0;
        phase_left = 0;
        mode       = 0;
        chars_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                chars_if.ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = $urandom_range(0, 2);
                    phase_left = $urandom_range(10, 80);
                end
                else
                    phase_left--;
                case (mode)
                    0:       chars_if.ready <= 1'b1;
                    1:       chars_if.ready <= ($urandom_range(0, 3) != 0);
                    default: chars_if.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : char_check
        digit_item_t want;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            chars_seen++;
            if (pending_digits.size() == 0)
            begin
                $error("unexpected character %h (last_digit %b)",
                       chars_if.digit_char, chars_if.last_digit);
                error_count++;
            end
            else
            begin
                want = pending_digits.pop_front();
                if (chars_if.digit_char !== want.ch)
                begin
                    $error("digit_char: expected %h, got %h", want.ch, chars_if.digit_char);
                    error_count++;
                end
                if (chars_if.last_digit !== want.last)
                begin
                    $error("last_digit: expected %b, got %b", want.last, chars_if.last_digit);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count   = 0;
        values_sent   = 0;
        chars_seen    = 0;
        radix_writes  = 0;
        burst_left    = 0;
        hold_request  = 1'b0;
        radix_setting = RADIX_RESET;
        rst_n            <= 1'b0;
        number_if.valid  <= 1'b0;
        number_if.value  <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.radix     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_radix();
        test_radix_extremes();
        test_random_values();
        test_output_backpressure();

        wait_for_drain();
        repeat (TAIL_WAIT) @(posedge clk);
        if (pending_digits.size() != 0)
        begin
            $error("%0d characters never arrived", pending_digits.size());
            error_count++;
        end

        $display("Converted %0d values into %0d characters across %0d radix writes,",
                 values_sent, chars_seen, radix_writes);
        $display("including clamped radix codes and a %0d-cycle output stall.", LONG_HOLD);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: integer_to_radix_ascii.f
+incdir+sv
sv/itra_pkg.sv
sv/itra_if.sv
sv/itra_datapath.sv
sv/itra_ctrl.sv
sv/integer_to_radix_ascii.sv
bench/integer_to_radix_ascii_tb.sv
